// File: rtl/core/sdc_pkg.sv
package sdc_pkg;

	// Depth of the job queue between the front and the back end.
	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW = $clog2(QDepth);

	// Bus constants.
	localparam logic [7:0] IdleByte = 8'hFF;
	localparam logic [7:0] CmdStartBit = 8'h40;
	localparam logic [7:0] PollLimitReset = 8'd128;

	// Input word actions.
	localparam logic ActIssue = 1'b0;
	localparam logic ActRecv = 1'b1;

	// Byte positions of an outgoing command run.
	localparam logic [3:0] StepDeselect = 4'd0;
	localparam logic [3:0] StepSelect = 4'd1;
	localparam logic [3:0] StepCmd = 4'd2;
	localparam logic [3:0] StepArg3 = 4'd3;
	localparam logic [3:0] StepArg2 = 4'd4;
	localparam logic [3:0] StepArg1 = 4'd5;
	localparam logic [3:0] StepArg0 = 4'd6;
	localparam logic [3:0] StepCrc = 4'd7;
	localparam logic [3:0] StepPollCrc = 4'd8;

	// One job handed from the front end to the back end. A frame job expands into
	// a whole command run; any other job is a single poll or response word.
	typedef struct packed {
		logic        is_frame;
		logic [7:0]  cmd;
		logic [31:0] arg;
		logic        crc_en;
		logic        is_poll;
		logic [7:0]  resp;
		logic        no_answer;
	} sdc_job_t;

endpackage

// File: rtl/core/sdc_if.sv
// Input channel: one word is either a command issue or a byte received from the card.
interface sdc_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  command_byte;
	logic [31:0] argument;
	logic        crc_enable;
	logic [7:0]  received_byte;

	modport source (output valid, action, command_byte, argument, crc_enable, received_byte,
		input ready);
	modport sink (input valid, action, command_byte, argument, crc_enable, received_byte,
		output ready);
endinterface

// Output channel: one word is a bus byte to exchange or the command's response.
interface sdc_out_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       select_asserted;
	logic       last_in_run;
	logic       response_valid;
	logic [7:0] response;
	logic       no_answer;

	modport source (output valid, tx_valid, tx_byte, select_asserted, last_in_run,
		response_valid, response, no_answer, input ready);
	modport sink (input valid, tx_valid, tx_byte, select_asserted, last_in_run,
		response_valid, response, no_answer, output ready);
endinterface

// File: rtl/core/sdc_front.sv
module sdc_front (
	input  logic             clk,
	input  logic             arst_n,
	sdc_in_if.sink           req,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             full,
	output logic             push,
	output sdc_pkg::sdc_job_t push_job
);
	import sdc_pkg::*;

	logic       accept;
	logic       awaiting_q;
	logic [7:0] poll_count_q;
	logic [7:0] poll_limit_q;
	logic       got_answer;
	logic       give_up;

	// Words are taken whenever the queue has room.
	assign req.ready = !full;
	assign accept = req.valid && !full;

	assign got_answer = (req.received_byte != IdleByte);
	assign give_up = (poll_count_q >= poll_limit_q);

	// Classify the word and build the job for the back end.
	always_comb begin
		push = 1'b0;
		push_job = '0;
		push_job.cmd = req.command_byte | CmdStartBit;
		push_job.arg = req.argument;
		push_job.crc_en = req.crc_enable;
		if (accept) begin
			if (req.action == ActIssue) begin
				push = 1'b1;
				push_job.is_frame = 1'b1;
			end else if (awaiting_q) begin
				push = 1'b1;
				if (got_answer) begin
					push_job.resp = req.received_byte;
				end else if (give_up) begin
					push_job.resp = IdleByte;
					push_job.no_answer = 1'b1;
				end else begin
					push_job.is_poll = 1'b1;
				end
			end
		end
	end

	// Response tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			poll_count_q <= '0;
		end else if (accept) begin
			if (req.action == ActIssue) begin
				awaiting_q <= 1'b1;
				poll_count_q <= '0;
			end else if (awaiting_q) begin
				if (got_answer || give_up) begin
					awaiting_q <= 1'b0;
				end else begin
					poll_count_q <= poll_count_q + 8'd1;
				end
			end
		end
	end

	// Poll limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= PollLimitReset;
		end else if (cfg_we) begin
			poll_limit_q <= cfg_wdata;
		end
	end

endmodule

// File: rtl/core/sdc_queue.sv
module sdc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sdc_pkg::sdc_job_t push_job,
	input  logic              pop,
	output sdc_pkg::sdc_job_t pop_job,
	output logic              full,
	output logic              empty
);
	import sdc_pkg::*;

	sdc_job_t           slot_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QPtrW:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign full = (count_q == (QPtrW + 1)'(QDepth));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_job = slot_q[rd_ptr_q];

	// Slot storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/sdc_back.sv
module sdc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  sdc_pkg::sdc_job_t pop_job,
	output logic              pop,
	sdc_out_if.source         rsp
);
	import sdc_pkg::*;

	// One byte of CRC7 (x^7 + x^3 + 1), most significant bit first.
	function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
		logic [6:0] crc;
		logic       fb;
		crc = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb = data[i] ^ crc[6];
			crc = {crc[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
		end
		return crc;
	endfunction

	sdc_job_t   job_q;
	logic       busy_q;
	logic [3:0] step_q;
	logic [6:0] crc_q;
	logic [3:0] last_step;
	logic [7:0] frame_byte;
	logic       last;
	logic       fire;
	logic       done;
	logic       load;

	// Byte of the command run at the current position.
	always_comb begin
		case (step_q)
			StepCmd:     frame_byte = job_q.cmd;
			StepArg3:    frame_byte = job_q.arg[31:24];
			StepArg2:    frame_byte = job_q.arg[23:16];
			StepArg1:    frame_byte = job_q.arg[15:8];
			StepArg0:    frame_byte = job_q.arg[7:0];
			StepCrc:     frame_byte = job_q.crc_en ? {crc_q, 1'b1} : IdleByte;
			default:     frame_byte = IdleByte;
		endcase
	end

	assign last_step = job_q.crc_en ? StepPollCrc : StepCrc;
	assign last = !job_q.is_frame || (step_q == last_step);

	// Output word, driven from the job register and the step counter.
	always_comb begin
		rsp.valid = busy_q;
		rsp.last_in_run = last;
		if (job_q.is_frame) begin
			rsp.tx_valid = 1'b1;
			rsp.tx_byte = frame_byte;
			rsp.select_asserted = (step_q != StepDeselect);
			rsp.response_valid = 1'b0;
			rsp.response = '0;
			rsp.no_answer = 1'b0;
		end else begin
			rsp.tx_valid = job_q.is_poll;
			rsp.tx_byte = job_q.is_poll ? IdleByte : 8'h00;
			rsp.select_asserted = 1'b1;
			rsp.response_valid = !job_q.is_poll;
			rsp.response = job_q.is_poll ? 8'h00 : job_q.resp;
			rsp.no_answer = !job_q.is_poll && job_q.no_answer;
		end
	end

	// A new job is taken as soon as the last word of the previous one leaves.
	assign fire = busy_q && rsp.ready;
	assign done = fire && last;
	assign load = !empty && (!busy_q || done);
	assign pop = load;

	// Job register.
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= pop_job;
		end
	end

	// Sequencer: byte position and running CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= StepDeselect;
			crc_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			step_q <= StepDeselect;
			crc_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			step_q <= step_q + 4'd1;
			if (step_q inside {[StepCmd:StepArg0]}) begin
				crc_q <= crc7_byte(crc_q, frame_byte);
			end
		end
	end

endmodule

// File: rtl/core/sd_spi_command_engine.sv
// Host side of one SD card command over SPI.
// req takes one word per cycle unless full: an issue word (action 0) frames a command,
// a receive word (action 1) hands in the byte read during the last poll exchange.
// rsp returns one word per cycle unless stalled. An issue yields 8 words (9 with CRC):
// 0xFF with select released, 0xFF selected, command, four argument bytes, the CRC7
// byte when enabled, and one 0xFF poll. A receive word yields one word, either another
// poll or the R1 response; receive words while no response is pending yield nothing.
// cfg_we/cfg_wdata write the poll limit (extra polls before no_answer is flagged).
// An accepted word is held in a queue slot and then in the back end's job register
// before its first result; the back end sends one word per cycle while rsp is ready.
// A two-entry job queue sits between the front end and the back end, so req keeps
// accepting while rsp stalls until the queue fills; results are never dropped.
// Reset clears the queue and the pending response and sets the poll limit to 128.
module sd_spi_command_engine (
	input  logic       clk,
	input  logic       arst_n,
	sdc_in_if.sink     req,
	sdc_out_if.source  rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	import sdc_pkg::*;

	sdc_job_t push_job;
	sdc_job_t pop_job;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;

	sdc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.full     (full),
		.push     (push),
		.push_job (push_job)
	);

	sdc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.full    (full),
		.empty   (empty)
	);

	sdc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.pop_job(pop_job),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

// File: rtl/core/sdc_checker.sv
module sdc_assertions (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic       select_asserted,
	input logic       last_in_run,
	input logic       response_valid,
	input logic [7:0] response,
	input logic       no_answer
);
	import sdc_pkg::*;

	// A stalled word holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(tx_byte) && $stable(last_in_run)
			&& $stable(response) && $stable(select_asserted))
		else $error("output word changed while stalled");

	// A response word ends its run, sends nothing and keeps the card selected.
	a_resp_shape: assert property (@(posedge clk) disable iff (!arst_n)
		valid && response_valid |-> !tx_valid && last_in_run && select_asserted)
		else $error("malformed response word");

	// Giving up reports an idle response byte.
	a_no_answer: assert property (@(posedge clk) disable iff (!arst_n)
		valid && no_answer |-> response_valid && response == IdleByte)
		else $error("no_answer without idle response");

	// The released-select byte is an idle byte that opens a run.
	a_deselect: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !select_asserted |-> tx_valid && tx_byte == IdleByte && !last_in_run)
		else $error("bad released-select word");

	// The run continues without a bubble after the released-select byte.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && !select_asserted |=> valid && select_asserted && tx_valid)
		else $error("run broken after released-select word");

endmodule

bind sd_spi_command_engine sdc_assertions u_sdc_assertions (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (rsp.valid),
	.ready          (rsp.ready),
	.tx_valid       (rsp.tx_valid),
	.tx_byte        (rsp.tx_byte),
	.select_asserted(rsp.select_asserted),
	.last_in_run    (rsp.last_in_run),
	.response_valid (rsp.response_valid),
	.response       (rsp.response),
	.no_answer      (rsp.no_answer)
);

// File: tb/sdc_checker.sv
// Watches both channels of the command engine, predicts every output word
// from the accepted input words and compares them in order.
module sdc_checker (
	input  logic       clk,
	input  logic       arst_n,
	sdc_in_if          req,
	sdc_out_if         rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output int         mismatches,
	output int         words_due
);
	import sdc_pkg::*;

	// One output word of the engine, in port order.
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       select_asserted;
		logic       last_in_run;
		logic       response_valid;
		logic [7:0] response;
		logic       no_answer;
	} bus_word_t;

	logic [7:0] poll_limit_q;
	logic       cmd_pending;
	logic [7:0] polls_sent;
	bus_word_t  bus_words_due[$];
	int         words_seen;

	// CRC7 with polynomial x^7 + x^3 + 1, one byte at a time, MSB first.
	function automatic logic [6:0] crc7_step(input logic [6:0] crc, input logic [7:0] data);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = data[i] ^ crc[6];
			crc = {crc[5:0], 1'b0};
			if (fb) begin
				crc = crc ^ 7'h09;
			end
		end
		return crc;
	endfunction

	function automatic bus_word_t tx_word(input logic [7:0] b, input logic sel, input logic last);
		bus_word_t w;
		w = '0;
		w.tx_valid = 1'b1;
		w.tx_byte = b;
		w.select_asserted = sel;
		w.last_in_run = last;
		return w;
	endfunction

	function automatic string show_word(input bus_word_t w);
		return $sformatf("tx %0b %02h sel %0b last %0b rsp %0b %02h na %0b", w.tx_valid,
			w.tx_byte, w.select_asserted, w.last_in_run, w.response_valid, w.response,
			w.no_answer);
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("checker: %s", what);
	endtask

	// Works out the words that one accepted input word causes and queues them.
	task automatic derive_bus_words(input logic act, input logic [7:0] cmd,
		input logic [31:0] arg, input logic crc_en, input logic [7:0] rx);
		logic [7:0] frame [5];
		logic [6:0] crc;
		bus_word_t  w;
		if (act == ActIssue) begin
			frame[0] = cmd | CmdStartBit;
			frame[1] = arg[31:24];
			frame[2] = arg[23:16];
			frame[3] = arg[15:8];
			frame[4] = arg[7:0];
			crc = '0;
			bus_words_due.push_back(tx_word(IdleByte, 1'b0, 1'b0));
			bus_words_due.push_back(tx_word(IdleByte, 1'b1, 1'b0));
			for (int i = 0; i < 5; i++) begin
				crc = crc7_step(crc, frame[i]);
				bus_words_due.push_back(tx_word(frame[i], 1'b1, 1'b0));
			end
			if (crc_en) begin
				bus_words_due.push_back(tx_word({crc, 1'b1}, 1'b1, 1'b0));
			end
			bus_words_due.push_back(tx_word(IdleByte, 1'b1, 1'b1));
			cmd_pending = 1'b1;
			polls_sent = '0;
		end else if (cmd_pending) begin
			// A real answer, or giving up once the poll budget is spent.
			if (rx != IdleByte || polls_sent >= poll_limit_q) begin
				w = '0;
				w.select_asserted = 1'b1;
				w.last_in_run = 1'b1;
				w.response_valid = 1'b1;
				w.response = rx;
				w.no_answer = (rx == IdleByte);
				bus_words_due.push_back(w);
				cmd_pending = 1'b0;
			end else begin
				polls_sent = polls_sent + 8'd1;
				bus_words_due.push_back(tx_word(IdleByte, 1'b1, 1'b1));
			end
		end
	endtask

	// Output words are checked before the input word of the same edge is predicted;
	// the engine's latency keeps the two apart.
	always @(posedge clk or negedge arst_n) begin
		bus_word_t got;
		bus_word_t want;
		if (!arst_n) begin
			poll_limit_q = PollLimitReset;
			cmd_pending = 1'b0;
			polls_sent = '0;
			bus_words_due.delete();
			words_seen = 0;
			mismatches = 0;
			words_due = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = {rsp.tx_valid, rsp.tx_byte, rsp.select_asserted, rsp.last_in_run,
					rsp.response_valid, rsp.response, rsp.no_answer};
				words_seen++;
				if (bus_words_due.size() == 0) begin
					report_mismatch($sformatf("word %0d not expected: %s", words_seen,
						show_word(got)));
				end else begin
					want = bus_words_due.pop_front();
					if (got !== want) begin
						report_mismatch($sformatf("word %0d: got %s, want %s", words_seen,
							show_word(got), show_word(want)));
					end
				end
			end
			if (cfg_we) begin
				poll_limit_q = cfg_wdata;
			end
			if (req.valid && req.ready) begin
				derive_bus_words(req.action, req.command_byte, req.argument, req.crc_enable,
					req.received_byte);
			end
			words_due = bus_words_due.size();
		end
	end

endmodule

// File: tb/sd_spi_command_engine_test.sv
// Drives commands and card bytes into the engine and gives the verdict; all
// prediction and comparison happens in the checker.
module sd_spi_command_engine_test;
	import sdc_pkg::*;

	localparam int ClockHigh = 6;
	localparam int ClockLow = 6;
	localparam int ResetCycles = 7;
	localparam int CycleLimit = 600000;
	localparam int SettleCycles = 12;
	localparam int TargetWords = 260;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         cycle_count;
	int         mismatches;
	int         words_due;

	// Sender bookkeeping: enough of the response state to keep sequences well formed.
	int         burst_left;
	int         sent_words;
	logic       cmd_waiting;
	int         polls_done;
	logic [7:0] limit_now;

	// Receiver stall pattern.
	logic [15:0] ready_pattern;
	int          stall_age;

	sdc_in_if  req ();
	sdc_out_if rsp ();

	sd_spi_command_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	sdc_checker engine_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mismatches(mismatches),
		.words_due (words_due)
	);

	always begin
		clk = 1'b0;
		#ClockLow;
		clk = 1'b1;
		#ClockHigh;
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CycleLimit);
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: rotates a 16-bit ready pattern and picks a new one when its age counter runs out.
	always @(posedge clk) begin
		if (stall_age == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern = 16'hFFFF;
				1: ready_pattern = 16'($urandom);
				2: ready_pattern = 16'hAAAA;
				default: ready_pattern = 16'($urandom) | 16'($urandom);
			endcase
			stall_age = 48;
		end
		rsp.ready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
		stall_age--;
	end

	// Offers one word and returns at the edge that accepts it. Between bursts valid
	// drops for a random gap.
	task automatic send_word(input logic act, input logic [7:0] cmd, input logic [31:0] arg,
		input logic crc_en, input logic [7:0] rx);
		if (burst_left == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.command_byte <= cmd;
		req.argument <= arg;
		req.crc_enable <= crc_en;
		req.received_byte <= rx;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		burst_left--;
	endtask

	task automatic issue_command(input logic [7:0] cmd, input logic [31:0] arg,
		input logic crc_en);
		send_word(ActIssue, cmd, arg, crc_en, 8'($urandom));
		cmd_waiting = 1'b1;
		polls_done = 0;
		sent_words++;
	endtask

	// Hands in a byte from the card; while no command waits it is ignored.
	task automatic hand_in(input logic [7:0] b);
		send_word(ActRecv, 8'($urandom), $urandom, 1'($urandom), b);
		if (cmd_waiting) begin
			sent_words++;
			if (b != IdleByte || polls_done >= limit_now) begin
				cmd_waiting = 1'b0;
			end else begin
				polls_done++;
			end
		end
	endtask

	// The poll limit is only written once the engine has drained.
	task automatic set_poll_limit(input logic [7:0] v);
		req.valid <= 1'b0;
		@(posedge clk);
		wait (words_due == 0);
		repeat (SettleCycles) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_now = v;
	endtask

	initial begin
		logic [7:0] new_limit;
		int         polls;
		int         next_phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.action = ActIssue;
		req.command_byte = '0;
		req.argument = '0;
		req.crc_enable = 1'b0;
		req.received_byte = '0;
		rsp.ready = 1'b0;
		burst_left = 0;
		sent_words = 0;
		cmd_waiting = 1'b0;
		polls_done = 0;
		limit_now = PollLimitReset;
		next_phase = 0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes, a byte while idle, an abandoned command,
		// and the poll limit at zero, one and its maximum.
		hand_in(8'h00);
		issue_command(8'h00, 32'h0000_0000, 1'b1);
		hand_in(IdleByte);
		hand_in(8'h01);
		issue_command(8'hFF, 32'hFFFF_FFFF, 1'b0);
		hand_in(8'h00);
		issue_command(8'h08, 32'h0000_01AA, 1'b1);
		hand_in(IdleByte);
		issue_command(8'h37, 32'h8000_0001, 1'b0);
		hand_in(8'hFE);
		set_poll_limit(8'd0);
		issue_command(8'h3A, 32'h5555_AAAA, 1'b1);
		hand_in(IdleByte);
		hand_in(IdleByte);
		set_poll_limit(8'd1);
		issue_command(8'h29, 32'h4000_0000, 1'b1);
		hand_in(IdleByte);
		hand_in(IdleByte);
		set_poll_limit(8'd255);
		issue_command(8'h11, 32'h0123_4567, 1'b0);
		repeat (3) hand_in(IdleByte);
		hand_in(8'h7F);

		// Random part: commands with random content, a run of idle polls, and mostly
		// a real answer; now and then noise or an abandoned command.
		while (sent_words < TargetWords) begin
			if (sent_words >= next_phase) begin
				case ($urandom_range(0, 5))
					0: new_limit = 8'd0;
					1: new_limit = 8'd1;
					2, 3: new_limit = 8'($urandom_range(2, 6));
					4: new_limit = 8'd255;
					default: new_limit = PollLimitReset;
				endcase
				set_poll_limit(new_limit);
				next_phase = sent_words + 45;
			end
			if ($urandom_range(0, 7) == 0) begin
				hand_in(8'($urandom));
			end
			issue_command(8'($urandom), $urandom, 1'($urandom));
			if (limit_now <= 8 && $urandom_range(0, 2) == 0) begin
				polls = limit_now + 1;
			end else begin
				polls = $urandom_range(0, (limit_now < 5) ? limit_now : 5);
			end
			for (int i = 0; i < polls && cmd_waiting; i++) begin
				hand_in(IdleByte);
			end
			if (cmd_waiting && $urandom_range(0, 7) != 0) begin
				hand_in(8'($urandom_range(0, 254)));
			end
		end

		// Drain and decide.
		req.valid <= 1'b0;
		@(posedge clk);
		wait (words_due == 0);
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/sdc_pkg.sv
rtl/core/sdc_if.sv
rtl/core/sdc_front.sv
rtl/core/sdc_queue.sv
rtl/core/sdc_back.sv
rtl/core/sd_spi_command_engine.sv
rtl/core/sdc_checker.sv
tb/sdc_checker.sv
tb/sd_spi_command_engine_test.sv
